// File: sv/utf8_stream_decoder_defines.svh
// Assertion macros shared by the UTF-8 stream decoder RTL.
// No dependencies; included by the files that carry assertions.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define U8D_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("utf8_stream_decoder: assertion failed");

// Next-cycle implication, checked outside reset.
`define U8D_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("utf8_stream_decoder: assertion failed");

`endif

// File: sv/utf8d_pkg.sv
// Types and constants of the UTF-8 stream decoder.
// No dependencies; used by every module of the block.
`default_nettype none

package utf8d_pkg;

    localparam int CpWidth    = 21;
    localparam int CmdDepth   = 4;
    localparam int CmdAw      = $clog2(CmdDepth);

    localparam logic [CpWidth-1:0] ReplCp  = 21'h00FFFD;
    localparam logic [CpWidth-1:0] Min2    = 21'h000080;
    localparam logic [CpWidth-1:0] Min3    = 21'h000800;
    localparam logic [CpWidth-1:0] Min4    = 21'h010000;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } in_t;

    typedef struct packed {
        logic [CpWidth-1:0] code_point;
        logic               run_last;
    } out_t;

    // One request's worth of output: cnt results, all U+FFFD but the last,
    // which carries cp.
    typedef struct packed {
        logic [2:0]         cnt;
        logic [CpWidth-1:0] cp;
    } cmd_t;

endpackage

`default_nettype wire

// File: sv/utf8d_front.sv
// Front end: accepts bytes, tracks the pending sequence and classifies each
// byte into at most one output command. Depends on utf8d_pkg.
`default_nettype none

module utf8d_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           accept,
    input  wire utf8d_pkg::in_t in_data,
    output logic                cmd_push,
    output utf8d_pkg::cmd_t     cmd_out
);
    import utf8d_pkg::*;

    logic [7:0]         lead_reg, lead_next;
    logic [1:0]         held_reg, held_next;
    logic [CpWidth-1:0] acc_reg, acc_next;
    logic               active_reg, active_next;

    logic [7:0]         b;
    logic               eos;
    logic               is_cont;
    logic [1:0]         need;
    logic [CpWidth-1:0] min_val;
    logic [CpWidth-1:0] acc_shift;
    logic [1:0]         held_inc;
    logic [2:0]         n_flush;

    assign b   = in_data.in_byte;
    assign eos = in_data.end_of_string;

    always_comb begin
        is_cont   = (b[7:6] == 2'b10);
        acc_shift = {acc_reg[CpWidth-7:0], b[5:0]};
        held_inc  = held_reg + 2'd1;
        if (lead_reg[7:5] == 3'b110) begin
            need    = 2'd1;
            min_val = Min2;
        end else if (lead_reg[7:4] == 4'b1110) begin
            need    = 2'd2;
            min_val = Min3;
        end else begin
            need    = 2'd3;
            min_val = Min4;
        end
        n_flush = active_reg ? (3'd1 + {1'b0, held_reg}) : 3'd0;

        lead_next   = 8'd0;
        held_next   = 2'd0;
        acc_next    = '0;
        active_next = 1'b0;
        cmd_out.cnt = 3'd0;
        cmd_out.cp  = ReplCp;

        if (active_reg && is_cont) begin
            if (held_inc >= need) begin
                cmd_out.cnt = 3'd1;
                cmd_out.cp  = (acc_shift < min_val) ? ReplCp : acc_shift;
            end else if (eos) begin
                cmd_out.cnt = 3'd1 + {1'b0, held_inc};
            end else begin
                lead_next   = lead_reg;
                held_next   = held_inc;
                acc_next    = acc_shift;
                active_next = 1'b1;
            end
        end else begin
            if (b < 8'h80) begin
                cmd_out.cnt = n_flush + 3'd1;
                cmd_out.cp  = {13'd0, b};
            end else if (b inside {[8'hC0:8'hF7]}) begin
                if (eos) begin
                    cmd_out.cnt = n_flush + 3'd1;
                end else begin
                    // A new lead byte: flush what was pending, then start over.
                    cmd_out.cnt = n_flush;
                    lead_next   = b;
                    active_next = 1'b1;
                    if (b[7:5] == 3'b110) begin
                        acc_next = {16'd0, b[4:0]};
                    end else if (b[7:4] == 4'b1110) begin
                        acc_next = {17'd0, b[3:0]};
                    end else begin
                        acc_next = {18'd0, b[2:0]};
                    end
                end
            end else begin
                cmd_out.cnt = n_flush + 3'd1;
            end
        end
        cmd_push = accept && (cmd_out.cnt != 3'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_reg   <= 8'd0;
            held_reg   <= 2'd0;
            acc_reg    <= '0;
            active_reg <= 1'b0;
        end else if (accept) begin
            lead_reg   <= lead_next;
            held_reg   <= held_next;
            acc_reg    <= acc_next;
            active_reg <= active_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/utf8d_cmd_fifo.sv
// Short command queue between the front and back ends of the decoder.
// Depends on utf8d_pkg for the command type and depth.
`default_nettype none

module utf8d_cmd_fifo (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire utf8d_pkg::cmd_t push_data,
    input  wire logic            pop,
    output utf8d_pkg::cmd_t      head,
    output logic                 empty,
    output logic                 full
);
    import utf8d_pkg::*;

    cmd_t             mem_reg [CmdDepth];
    logic [CmdAw-1:0] wr_ptr_reg;
    logic [CmdAw-1:0] rd_ptr_reg;
    logic [CmdAw:0]   count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (CmdAw+1)'(CmdDepth));
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/utf8d_back.sv
// Back end: expands each queued command into its results, one per cycle
// while m_ready does not stall it, into a registered output stage. Depends on utf8d_pkg.
`default_nettype none

module utf8d_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire utf8d_pkg::cmd_t head,
    input  wire logic            empty,
    output logic                 pop,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output utf8d_pkg::out_t      m_data
);
    import utf8d_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    out_t       data_reg, data_next;
    logic       issue;
    logic       is_last;

    always_comb begin
        issue    = !empty && (!valid_reg || m_ready);
        is_last  = (({1'b0, idx_reg} + 3'd1) == head.cnt);
        pop      = issue && is_last;
        idx_next = idx_reg;
        data_next = data_reg;
        valid_next = valid_reg && !m_ready;
        if (issue) begin
            valid_next          = 1'b1;
            data_next.code_point = is_last ? head.cp : ReplCp;
            data_next.run_last   = is_last;
            idx_next            = is_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

`default_nettype wire

// File: sv/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder with U+FFFD replacement.
// Depends on utf8d_pkg, utf8d_front, utf8d_cmd_fifo, utf8d_back and the defines header.
`default_nettype none
`include "utf8_stream_decoder_defines.svh"

// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   in_t  {in_byte, end_of_string}
// m_        out        m_valid / m_ready   out_t {code_point, run_last}
//
// The front end accepts a byte every cycle while the command queue (four entries)
// has room. A byte that yields k results (k up to 4) holds the back end until all
// k have gone, since the output register moves one result per cycle while m_ready
// is high. The first result of a byte passes through the command queue and then
// the output register, and can wait behind earlier commands or an output stall.
// Reset is synchronous and active low; it empties the queue and clears the
// pending sequence. Output stalls back up into the queue, then into s_ready.

module utf8_stream_decoder (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire utf8d_pkg::in_t s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output utf8d_pkg::out_t     m_data
);
    import utf8d_pkg::*;

    cmd_t cmd_in;
    cmd_t cmd_head;
    logic cmd_push;
    logic cmd_pop;
    logic cmd_empty;
    logic cmd_full;
    logic s_accept;

    // The front end only stalls when the queue is full; it never waits on
    // the output side directly.
    assign s_ready  = !cmd_full;
    assign s_accept = s_valid && s_ready;

    // Classifies each byte and keeps the pending multi-byte sequence.
    utf8d_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (s_accept),
        .in_data  (s_data),
        .cmd_push (cmd_push),
        .cmd_out  (cmd_in)
    );

    // Decouples byte intake from result delivery.
    utf8d_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_push),
        .push_data (cmd_in),
        .pop       (cmd_pop),
        .head      (cmd_head),
        .empty     (cmd_empty),
        .full      (cmd_full)
    );

    // Expands each command into its run of results.
    utf8d_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (cmd_head),
        .empty   (cmd_empty),
        .pop     (cmd_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // The queue is never written while full.
    `U8D_ASSERT_NOW(a_no_overflow, aclk, aresetn, cmd_push, !cmd_full)
    // Only commands that carry at least one result enter the queue.
    `U8D_ASSERT_NOW(a_cmd_nonempty, aclk, aresetn, cmd_push,
                    (cmd_in.cnt != 3'd0) && (cmd_in.cnt <= 3'd4))
    // A run of results for one byte goes out without a gap.
    `U8D_ASSERT_NEXT(a_run_no_gap, aclk, aresetn,
                     m_valid && m_ready && !m_data.run_last, m_valid)
    // A result other than the last of its run is always U+FFFD.
    `U8D_ASSERT_NOW(a_inner_repl, aclk, aresetn, m_valid && !m_data.run_last,
                    m_data.code_point == ReplCp)

endmodule

`default_nettype wire

// File: test/tb_utf8_stream_decoder.sv
// Self-checking testbench for utf8_stream_decoder: directed byte table, then random strings.
// Depends on utf8d_pkg and the decoder RTL; expected code points: table or in-file predictor.
`timescale 1ns / 100ps

module tb_utf8_stream_decoder;

    import utf8d_pkg::*;

    // Random bytes after the directed table; about 310 requests in all.
    localparam int RandBytes  = 285;
    // No idling on either side for the last stretch of the run.
    localparam int QuietBytes = 60;
    // Watchdog limit, with a wide margin over the slowest correct run.
    localparam int CycleLimit = 200000;
    // Cycles to wait after the last expected result.
    localparam int DrainCycles = 8;

    // Byte classes of UTF-8.
    localparam logic [7:0] ContMask   = 8'hC0;
    localparam logic [7:0] ContTag    = 8'h80;
    localparam logic [7:0] AsciiLimit = 8'h80;
    localparam logic [7:0] LeadFirst  = 8'hC0;
    localparam logic [7:0] LeadLast   = 8'hF7;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    always #2 aclk = ~aclk;

    utf8_stream_decoder DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // ------------------------------------------------------------------
    // Predictor: a shadow of the pending multi-byte sequence. Each byte
    // fed to decode_byte leaves the code points it causes in byte_results.
    // ------------------------------------------------------------------
    logic [7:0]         seq_lead;
    logic [1:0]         seq_conts;
    logic [CpWidth-1:0] seq_bits;
    logic               seq_open;
    out_t               byte_results[$];

    // Queue of code points the block still owes, oldest first.
    out_t               cp_pending[$];

    int failures = 0;
    int cycles   = 0;
    bit gaps_on  = 1'b0;

    function automatic int conts_for_lead(input logic [7:0] lead);
        if (lead[7:5] == 3'b110) begin
            return 1;
        end else if (lead[7:4] == 4'b1110) begin
            return 2;
        end
        return 3;
    endfunction

    function automatic logic [CpWidth-1:0] shortest_form(input int conts);
        if (conts == 1) begin
            return Min2;
        end else if (conts == 2) begin
            return Min3;
        end
        return Min4;
    endfunction

    function void emit_cp(input logic [CpWidth-1:0] cp);
        byte_results.insert(byte_results.size(), out_t'{code_point: cp, run_last: 1'b0});
    endfunction

    function void close_sequence();
        seq_lead  = '0;
        seq_conts = '0;
        seq_bits  = '0;
        seq_open  = 1'b0;
    endfunction

    // A broken or cut-off sequence: one U+FFFD for the lead byte and one for
    // every continuation byte already taken.
    function void flush_sequence();
        emit_cp(ReplCp);
        for (int k = 0; k < int'(seq_conts); k++) begin
            emit_cp(ReplCp);
        end
        close_sequence();
    endfunction

    function void decode_byte(input logic [7:0] b, input logic eos);
        int need;
        byte_results.delete();
        if (seq_open && (b & ContMask) == ContTag) begin
            need      = conts_for_lead(seq_lead);
            seq_bits  = {seq_bits[CpWidth-7:0], b[5:0]};
            seq_conts = seq_conts + 2'd1;
            if (int'(seq_conts) >= need) begin
                // Complete sequence; overlong encodings collapse to one U+FFFD.
                emit_cp(seq_bits < shortest_form(need) ? ReplCp : seq_bits);
                close_sequence();
            end else if (eos) begin
                flush_sequence();
            end
        end else begin
            // Anything else breaks a pending sequence, then starts afresh.
            if (seq_open) begin
                flush_sequence();
            end
            if (b < AsciiLimit) begin
                emit_cp({13'd0, b});
            end else if (b >= LeadFirst && b <= LeadLast) begin
                if (eos) begin
                    emit_cp(ReplCp);
                end else begin
                    seq_lead  = b;
                    seq_conts = '0;
                    if (b[7:5] == 3'b110) begin
                        seq_bits = {16'd0, b[4:0]};
                    end else if (b[7:4] == 4'b1110) begin
                        seq_bits = {17'd0, b[3:0]};
                    end else begin
                        seq_bits = {18'd0, b[2:0]};
                    end
                    seq_open = 1'b1;
                end
            end else begin
                emit_cp(ReplCp);
            end
        end
        if (byte_results.size() > 0) begin
            byte_results[byte_results.size() - 1].run_last = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Directed table. Where fixed is set, the row's results are typed in:
    // n_results code points, all U+FFFD but the last, which is last_cp.
    // Other rows are checked against the predictor.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [7:0]         in_byte;
        logic               eos;
        logic               fixed;
        logic [2:0]         n_results;
        logic [CpWidth-1:0] last_cp;
    } byte_row_t;

    localparam int NumRows = 25;

    byte_row_t byte_table [0:NumRows-1] = '{
        '{8'h00, 1'b0, 1'b1, 3'd1, 21'h000000},  // lowest ASCII passes through
        '{8'h7F, 1'b1, 1'b1, 3'd1, 21'h00007F},  // highest ASCII, ends a string
        '{8'h80, 1'b0, 1'b1, 3'd1, ReplCp},      // stray continuation byte
        '{8'hFF, 1'b0, 1'b1, 3'd1, ReplCp},      // never valid in UTF-8
        '{8'hF8, 1'b0, 1'b1, 3'd1, ReplCp},      // lowest of the invalid leads
        '{8'hC3, 1'b0, 1'b1, 3'd0, 21'h000000},  // two-byte lead, nothing yet
        '{8'hA9, 1'b0, 1'b0, 3'd0, 21'h000000},
        '{8'hE2, 1'b0, 1'b1, 3'd0, 21'h000000},  // three-byte sequence
        '{8'h82, 1'b0, 1'b1, 3'd0, 21'h000000},
        '{8'hAC, 1'b0, 1'b0, 3'd0, 21'h000000},
        '{8'hC0, 1'b0, 1'b1, 3'd0, 21'h000000},  // overlong two-byte form
        '{8'h80, 1'b0, 1'b1, 3'd1, ReplCp},
        '{8'hF7, 1'b0, 1'b1, 3'd0, 21'h000000},  // largest four-byte value
        '{8'hBF, 1'b0, 1'b1, 3'd0, 21'h000000},
        '{8'hBF, 1'b0, 1'b1, 3'd0, 21'h000000},
        '{8'hBF, 1'b0, 1'b0, 3'd0, 21'h000000},
        '{8'hF0, 1'b0, 1'b1, 3'd0, 21'h000000},  // four-byte lead, then broken
        '{8'h90, 1'b0, 1'b1, 3'd0, 21'h000000},
        '{8'h80, 1'b0, 1'b1, 3'd0, 21'h000000},
        '{8'h41, 1'b1, 1'b1, 3'd4, 21'h000041},  // three U+FFFD, then the ASCII
        '{8'hED, 1'b0, 1'b1, 3'd0, 21'h000000},  // string ends mid-sequence
        '{8'hA0, 1'b1, 1'b1, 3'd2, ReplCp},
        '{8'hC2, 1'b1, 1'b1, 3'd1, ReplCp},      // lead byte that ends a string
        '{8'hE0, 1'b0, 1'b1, 3'd0, 21'h000000},  // sequence broken by a new lead
        '{8'hC2, 1'b0, 1'b1, 3'd1, ReplCp}
    };

    // Holds one request on the input channel until it is accepted, with a
    // random burst of idle cycles in front of it now and then while idling is enabled.
    // Valid is only lowered for a gap, so back-to-back requests keep it high.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{in_byte: b, end_of_string: eos};
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    // Updates the predictor, queues what this byte owes, then sends it.
    task automatic feed_byte(input logic [7:0] b, input logic eos, input logic fixed,
                             input logic [2:0] n_results, input logic [CpWidth-1:0] last_cp);
        decode_byte(b, eos);
        if (fixed) begin
            for (int k = 1; k <= int'(n_results); k++) begin
                cp_pending.insert(cp_pending.size(),
                                  out_t'{code_point: (k == int'(n_results)) ? last_cp : ReplCp,
                                         run_last:   (k == int'(n_results))});
            end
        end else begin
            foreach (byte_results[k]) begin
                cp_pending.insert(cp_pending.size(), byte_results[k]);
            end
        end
        send_byte(b, eos);
    endtask

    // Appends a lead byte for a sequence of seq_len bytes and seq_len - 1
    // continuation bytes, all with random payload bits.
    task automatic build_sequence(input int seq_len, ref logic [7:0] bytes_out[$]);
        case (seq_len)
            2: begin
                bytes_out.insert(bytes_out.size(), 8'hC0 | 8'($urandom_range(0, 31)));
            end
            3: begin
                bytes_out.insert(bytes_out.size(), 8'hE0 | 8'($urandom_range(0, 15)));
            end
            default: begin
                bytes_out.insert(bytes_out.size(), 8'hF0 | 8'($urandom_range(0, 7)));
            end
        endcase
        for (int k = 1; k < seq_len; k++) begin
            bytes_out.insert(bytes_out.size(), ContTag | 8'($urandom_range(0, 63)));
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus: reset, the directed table, then random strings made mostly
    // of well-formed sequences, with cut-off sequences, stray bytes and
    // arbitrary bytes mixed in.
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0] chunk[$];
        int         bytes_sent;
        int         kind;
        int         seq_len;
        logic       eos;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        close_sequence();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        gaps_on = 1'b1;
        for (int r = 0; r < NumRows; r++) begin
            feed_byte(byte_table[r].in_byte, byte_table[r].eos, byte_table[r].fixed,
                      byte_table[r].n_results, byte_table[r].last_cp);
        end

        bytes_sent = 0;
        while (bytes_sent < RandBytes) begin
            chunk.delete();
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1: begin
                    chunk.insert(chunk.size(), 8'($urandom_range(0, 127)));
                end
                2, 3, 4, 5: begin
                    build_sequence($urandom_range(2, 4), chunk);
                end
                6, 7: begin
                    // Cut-off sequence: the next chunk breaks it unless it starts with a continuation byte.
                    seq_len = $urandom_range(2, 4);
                    build_sequence(seq_len, chunk);
                    repeat ($urandom_range(1, seq_len - 1)) void'(chunk.pop_back());
                end
                8: begin
                    // Stray continuation byte or one of the invalid leads.
                    if ($urandom_range(0, 1) == 0) begin
                        chunk.insert(chunk.size(), 8'($urandom_range(8'h80, 8'hBF)));
                    end else begin
                        chunk.insert(chunk.size(), 8'($urandom_range(8'hF8, 8'hFF)));
                    end
                end
                default: begin
                    chunk.insert(chunk.size(), 8'($urandom_range(0, 255)));
                end
            endcase
            foreach (chunk[k]) begin
                // Strings mostly end at a chunk boundary, now and then mid-sequence.
                eos = (k == chunk.size() - 1 && $urandom_range(0, 4) == 0) ||
                      $urandom_range(0, 24) == 0;
                gaps_on = (bytes_sent < RandBytes - QuietBytes);
                feed_byte(chunk[k], eos, 1'b0, 3'd0, '0);
                bytes_sent++;
            end
        end
        s_valid <= 1'b0;

        // Wait for every owed code point, then a few more cycles so that a
        // late extra result would still be seen.
        while (cp_pending.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DrainCycles) @(posedge aclk);

        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: check each accepted code point against the oldest one
    // owed, and drive m_ready low in random stall bursts while idling is enabled.
    // m_ready and m_valid are read here before this edge's updates land.
    // ------------------------------------------------------------------
    out_t cp_owed;
    int   stall_left = 0;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (cp_pending.size() == 0) begin
                $display("%0t: unexpected code point: expected none, actual %h run_last %b",
                         $time, m_data.code_point, m_data.run_last);
                failures++;
            end else begin
                cp_owed = cp_pending.pop_front();
                if (m_data.code_point !== cp_owed.code_point) begin
                    $display("%0t: code_point mismatch: expected %h, actual %h",
                             $time, cp_owed.code_point, m_data.code_point);
                    failures++;
                end
                if (m_data.run_last !== cp_owed.run_last) begin
                    $display("%0t: run_last mismatch: expected %b, actual %b",
                             $time, cp_owed.run_last, m_data.run_last);
                    failures++;
                end
            end
        end

        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            stall_left = $urandom_range(0, 5);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CycleLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule

// File: sim.f
+incdir+sv
sv/utf8d_pkg.sv
sv/utf8d_front.sv
sv/utf8d_cmd_fifo.sv
sv/utf8d_back.sv
sv/utf8_stream_decoder.sv
test/tb_utf8_stream_decoder.sv
